@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers, clocked, with active-low reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/mfep_pkg.sv @@
// ----------------------------------------------------------------------------
// mfep_pkg
// Types and constants shared by the MIDI file event parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfep_pkg;

    typedef enum logic [2:0] {
        KIND_NOTE_OFF  = 3'd0,
        KIND_NOTE_ON   = 3'd1,
        KIND_CHANNEL   = 3'd2,
        KIND_END_TRACK = 3'd3,
        KIND_TEMPO     = 3'd4,
        KIND_BAD_STAT  = 3'd5,
        KIND_HEADER    = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  track;
        logic [7:0]   key;
        logic [7:0]   velocity;
        logic [31:0]  delta;
        logic [31:0]  abs_time;
        logic [23:0]  tempo;
        logic [15:0]  format;
        logic [15:0]  total;
        logic [15:0]  division;
    } t_result;

    localparam logic [3:0] FILE_HDR_BYTES  = 4'd14;
    localparam logic [3:0] TRACK_HDR_BYTES = 4'd8;

    localparam logic [7:0] STAT_META       = 8'hFF;
    localparam logic [7:0] STAT_SYSEX      = 8'hF0;
    localparam logic [7:0] STAT_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] META_END_TRACK  = 8'h2F;
    localparam logic [7:0] META_SET_TEMPO  = 8'h51;

    localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
    localparam logic [3:0] HI_NOTE_ON      = 4'h9;
    localparam logic [3:0] HI_PROGRAM      = 4'hC;
    localparam logic [3:0] HI_PRESSURE     = 4'hD;

endpackage

@@ rtl/mfep_core.sv @@
// ----------------------------------------------------------------------------
// mfep_core
// Byte-wise parse state and combinational next-state / event decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfep_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    output logic              o_res_valid,
    output mfep_pkg::t_result o_res
);
    import mfep_pkg::*;

    typedef enum logic [11:0] {
        PH_FILE_HDR   = 12'b0000_0000_0001,
        PH_TRACK_HDR  = 12'b0000_0000_0010,
        PH_DELTA      = 12'b0000_0000_0100,
        PH_STATUS     = 12'b0000_0000_1000,
        PH_DATA1      = 12'b0000_0001_0000,
        PH_DATA2      = 12'b0000_0010_0000,
        PH_META_TYPE  = 12'b0000_0100_0000,
        PH_META_LEN   = 12'b0000_1000_0000,
        PH_META_BODY  = 12'b0001_0000_0000,
        PH_SYSEX_LEN  = 12'b0010_0000_0000,
        PH_SYSEX_BODY = 12'b0100_0000_0000,
        PH_DONE       = 12'b1000_0000_0000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_cnt, n_cnt;
    logic [47:0]            r_hdr, n_hdr;
    logic [15:0]            r_track, n_track;
    logic [7:0]             r_run, n_run;
    logic [7:0]             r_act, n_act;
    logic [TIME_BITS-1:0]   r_delta, n_delta;
    logic [TIME_BITS-1:0]   r_time, n_time;
    logic [7:0]             r_first, n_first;
    logic [7:0]             r_meta, n_meta;
    logic [31:0]            r_skip, n_skip;
    logic [23:0]            r_tempo, n_tempo;

    logic                   l_emit;
    t_kind                  l_kind;
    logic [7:0]             l_key;
    logic [7:0]             l_vel;
    logic [23:0]            l_tempo;
    logic                   l_finish;
    logic [63:0]            w_delta_ext;
    logic [63:0]            w_time_ext;

    always_comb begin
        logic [7:0]           b;
        logic [3:0]           hi;
        logic [TIME_BITS-1:0] base;
        b        = i_data_byte;
        hi       = 4'h0;
        base     = '0;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_hdr    = r_hdr;
        n_track  = r_track;
        n_run    = r_run;
        n_act    = r_act;
        n_delta  = r_delta;
        n_time   = r_time;
        n_first  = r_first;
        n_meta   = r_meta;
        n_skip   = r_skip;
        n_tempo  = r_tempo;
        l_emit   = 1'b0;
        l_kind   = KIND_CHANNEL;
        l_key    = 8'h00;
        l_vel    = 8'h00;
        l_tempo  = 24'h0;
        l_finish = 1'b0;

        case (r_phase)
            PH_FILE_HDR: begin
                n_hdr = {r_hdr[39:0], b};
                n_cnt = r_cnt + 4'd1;
                if (n_cnt == FILE_HDR_BYTES) begin
                    n_cnt   = 4'd0;
                    n_phase = (n_hdr[31:16] == 16'h0) ? PH_DONE : PH_TRACK_HDR;
                    l_emit  = 1'b1;
                    l_kind  = KIND_HEADER;
                end
            end
            PH_TRACK_HDR: begin
                n_cnt = r_cnt + 4'd1;
                if (n_cnt == TRACK_HDR_BYTES) begin
                    n_time  = '0;
                    n_delta = '0;
                    n_run   = 8'h00;
                    n_act   = 8'h00;
                    n_cnt   = 4'd0;
                    n_phase = PH_DELTA;
                end
            end
            PH_DELTA: begin
                base    = (r_cnt == 4'd0) ? '0 : r_delta;
                n_cnt   = 4'd1;
                n_delta = {base[TIME_BITS-8:0], b[6:0]};
                if (!b[7]) begin
                    n_time  = r_time + n_delta;
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (r_run == 8'h00) begin
                        // orphan data byte: report, then take it as a full delta
                        l_emit  = 1'b1;
                        l_kind  = KIND_BAD_STAT;
                        n_delta = {{(TIME_BITS-8){1'b0}}, b};
                        n_time  = r_time + n_delta;
                    end else begin
                        n_act = r_run;
                        hi    = r_run[7:4];
                        if (hi inside {HI_PROGRAM, HI_PRESSURE}) begin
                            n_cnt   = 4'd0;
                            n_phase = PH_DELTA;
                            l_emit  = 1'b1;
                            l_kind  = KIND_CHANNEL;
                        end else begin
                            n_first = b;
                            n_phase = PH_DATA2;
                        end
                    end
                end else if (b[7:4] != 4'hF) begin
                    n_run   = b;
                    n_act   = b;
                    n_phase = PH_DATA1;
                end else begin
                    n_run = 8'h00;
                    n_act = b;
                    if (b == STAT_META) begin
                        n_phase = PH_META_TYPE;
                    end else if (b inside {STAT_SYSEX, STAT_SYSEX_ESC}) begin
                        n_skip  = 32'h0;
                        n_phase = PH_SYSEX_LEN;
                    end else begin
                        n_cnt   = 4'd0;
                        n_phase = PH_DELTA;
                    end
                end
            end
            PH_DATA1: begin
                hi = r_act[7:4];
                if (hi inside {HI_PROGRAM, HI_PRESSURE}) begin
                    n_cnt   = 4'd0;
                    n_phase = PH_DELTA;
                    l_emit  = 1'b1;
                    l_kind  = KIND_CHANNEL;
                end else begin
                    n_first = b;
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                hi      = r_act[7:4];
                n_cnt   = 4'd0;
                n_phase = PH_DELTA;
                l_emit  = 1'b1;
                if (hi == HI_NOTE_OFF) begin
                    l_kind = KIND_NOTE_OFF;
                    l_key  = r_first;
                    l_vel  = b;
                end else if (hi == HI_NOTE_ON) begin
                    l_kind = (b == 8'h00) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                    l_key  = r_first;
                    l_vel  = b;
                end else begin
                    l_kind = KIND_CHANNEL;
                end
            end
            PH_META_TYPE: begin
                n_meta  = b;
                n_skip  = 32'h0;
                n_phase = PH_META_LEN;
            end
            PH_META_LEN: begin
                n_skip = {r_skip[24:0], b[6:0]};
                if (!b[7]) begin
                    n_cnt   = 4'd0;
                    n_first = (r_meta == META_SET_TEMPO && r_tempo == 24'h0) ? 8'h01 : 8'h00;
                    if (n_skip == 32'h0) begin
                        l_finish = 1'b1;
                    end else begin
                        n_phase = PH_META_BODY;
                    end
                end
            end
            PH_META_BODY: begin
                // tempo bytes land big endian, only the first three count
                if (r_first != 8'h00 && r_cnt < 4'd3) begin
                    case (r_cnt)
                        4'd0:    n_tempo = r_tempo | {b, 16'h0};
                        4'd1:    n_tempo = r_tempo | {8'h0, b, 8'h0};
                        default: n_tempo = r_tempo | {16'h0, b};
                    endcase
                    n_cnt = r_cnt + 4'd1;
                end
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'h0) begin
                    l_finish = 1'b1;
                end
            end
            PH_SYSEX_LEN: begin
                n_skip = {r_skip[24:0], b[6:0]};
                if (!b[7]) begin
                    if (n_skip == 32'h0) begin
                        n_cnt   = 4'd0;
                        n_phase = PH_DELTA;
                    end else begin
                        n_phase = PH_SYSEX_BODY;
                    end
                end
            end
            PH_SYSEX_BODY: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'h0) begin
                    n_cnt   = 4'd0;
                    n_phase = PH_DELTA;
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (l_finish) begin
            n_cnt = 4'd0;
            if (r_meta == META_END_TRACK) begin
                l_emit  = 1'b1;
                l_kind  = KIND_END_TRACK;
                n_track = r_track + 16'd1;
                n_phase = (n_track >= r_hdr[31:16]) ? PH_DONE : PH_TRACK_HDR;
            end else begin
                n_phase = PH_DELTA;
                if (n_first != 8'h00 && n_tempo != 24'h0) begin
                    l_emit  = 1'b1;
                    l_kind  = KIND_TEMPO;
                    l_tempo = n_tempo;
                end
            end
        end
    end

    assign w_delta_ext = 64'(r_delta);
    assign w_time_ext  = 64'(r_time);

    // results carry pre-update delta/time/track; header words already shifted
    always_comb begin
        o_res_valid    = i_accept && l_emit;
        o_res.kind     = l_kind;
        o_res.track    = r_track;
        o_res.key      = l_key;
        o_res.velocity = l_vel;
        o_res.delta    = w_delta_ext[31:0];
        o_res.abs_time = w_time_ext[31:0];
        o_res.tempo    = l_tempo;
        o_res.format   = n_hdr[47:32];
        o_res.total    = n_hdr[31:16];
        o_res.division = n_hdr[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FILE_HDR;
            r_cnt   <= 4'd0;
            r_hdr   <= 48'h0;
            r_track <= 16'h0;
            r_run   <= 8'h00;
            r_act   <= 8'h00;
            r_delta <= '0;
            r_time  <= '0;
            r_first <= 8'h00;
            r_meta  <= 8'h00;
            r_skip  <= 32'h0;
            r_tempo <= 24'h0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hdr   <= n_hdr;
            r_track <= n_track;
            r_run   <= n_run;
            r_act   <= n_act;
            r_delta <= n_delta;
            r_time  <= n_time;
            r_first <= n_first;
            r_meta  <= n_meta;
            r_skip  <= n_skip;
            r_tempo <= n_tempo;
        end
    end

endmodule

@@ rtl/midi_file_event_parser.sv @@
// A completed event is registered into the result register, or the skid slot.
// Throughput: one byte per cycle while o_stall is low.
// A two-entry output buffer (result register plus skid) keeps input flowing
// while a result waits; input stalls only while both entries are full.
// Reset (synchronous, active low) returns the parser to the file header
// and empties the output buffer.
// ----------------------------------------------------------------------------
// midi_file_event_parser
// Standard MIDI file byte-stream parser emitting header, note, channel,
// end-of-track and tempo events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midi_file_event_parser #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_track_number,
    output logic [7:0]  o_note_key,
    output logic [7:0]  o_note_velocity,
    output logic [31:0] o_delta_ticks,
    output logic [31:0] o_absolute_ticks,
    output logic [23:0] o_tempo_value,
    output logic [15:0] o_file_format,
    output logic [15:0] o_track_total,
    output logic [15:0] o_time_division
);
    import mfep_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    logic    w_out_take;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_stall    = r_skid_valid;
    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_stall;

    mfep_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // control: result register and skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_out_take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_out.kind;
    assign o_track_number   = r_out.track;
    assign o_note_key       = r_out.key;
    assign o_note_velocity  = r_out.velocity;
    assign o_delta_ticks    = r_out.delta;
    assign o_absolute_ticks = r_out.abs_time;
    assign o_tempo_value    = r_out.tempo;
    assign o_file_format    = r_out.format;
    assign o_track_total    = r_out.total;
    assign o_time_division  = r_out.division;

    `ASSERT_CLK(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full with empty output register")
    `ASSERT_CLK(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && i_stall), "skid filled without a stalled output")
    `ASSERT_NEVER(a_tempo_nonzero, i_clk, i_rst_n, w_res_valid && w_res.kind == KIND_TEMPO && w_res.tempo == 24'h0, "tempo event with zero value")

endmodule

@@ test/midi_file_event_parser_tb.sv @@
// ----------------------------------------------------------------------------
// midi_file_event_parser_tb
// Self-checking bench for the MIDI file byte parser. A single file stream is
// built: the file header, a directed track for notes, channel messages, system
// and sysex, tempo and long delta times, then random tracks and a final track
// without idling, then trailing bytes the parser ignores. A predictor in the
// bench computes every event, and each output transaction is checked field by
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_file_event_parser_tb;
    import mfep_pkg::*;

    localparam int          TRACK_COUNT    = 12;
    localparam int          RANDOM_BYTES   = 1250;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] FILE_TAG       = 32'h4D54_6864;
    localparam logic [31:0] TRACK_TAG      = 32'h4D54_726B;
    localparam logic [3:0]  HI_POLY_PRESS  = 4'hA;
    localparam logic [3:0]  HI_CONTROL     = 4'hB;
    localparam logic [3:0]  HI_PITCH       = 4'hE;
    localparam logic [7:0]  STAT_SYS_FIRST = 8'hF1;
    localparam logic [7:0]  STAT_SYS_LAST  = 8'hFE;
    localparam logic [7:0]  META_TEXT      = 8'h01;

    typedef enum logic [3:0] {
        P_FILE_HDR, P_TRACK_HDR, P_DELTA, P_STATUS, P_DATA1, P_DATA2,
        P_META_TYPE, P_META_LEN, P_META_BODY, P_SYSEX_LEN, P_SYSEX_BODY, P_DONE
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_kind;
    logic [15:0] o_track_number;
    logic [7:0]  o_note_key;
    logic [7:0]  o_note_velocity;
    logic [31:0] o_delta_ticks;
    logic [31:0] o_absolute_ticks;
    logic [23:0] o_tempo_value;
    logic [15:0] o_file_format;
    logic [15:0] o_track_total;
    logic [15:0] o_time_division;

    midi_file_event_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_track_number   (o_track_number),
        .o_note_key       (o_note_key),
        .o_note_velocity  (o_note_velocity),
        .o_delta_ticks    (o_delta_ticks),
        .o_absolute_ticks (o_absolute_ticks),
        .o_tempo_value    (o_tempo_value),
        .o_file_format    (o_file_format),
        .o_track_total    (o_track_total),
        .o_time_division  (o_time_division)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_phase      ph = P_FILE_HDR;
    logic [3:0]  cnt = '0;
    logic [47:0] hdr = '0;
    logic [15:0] trk = '0;
    logic [7:0]  run_st = '0;
    logic [7:0]  act_st = '0;
    logic [31:0] delta_acc = '0;
    logic [31:0] trk_time = '0;
    logic [7:0]  first_d = '0;
    logic [7:0]  mtype = '0;
    logic [31:0] skip_len = '0;
    logic [23:0] tempo_st = '0;

    t_result pending_events[$];
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      idle_cycles = 0;
    bit      idle_enable = 1'b0;
    bit      stall_enable = 1'b0;
    logic [3:0] stall_left = '0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic post_event(input t_kind k, input logic [7:0] key, input logic [7:0] vel,
                              input logic [23:0] tmp);
        t_result r;
        r.kind     = k;
        r.track    = trk;
        r.key      = key;
        r.velocity = vel;
        r.delta    = delta_acc;
        r.abs_time = trk_time;
        r.tempo    = tmp;
        r.format   = hdr[47:32];
        r.total    = hdr[31:16];
        r.division = hdr[15:0];
        pending_events = {pending_events, r};
    endtask

    task automatic data_first(input logic [7:0] b);
        if (act_st[7:4] == HI_PROGRAM || act_st[7:4] == HI_PRESSURE) begin
            ph  = P_DELTA;
            cnt = '0;
            post_event(KIND_CHANNEL, 8'h00, 8'h00, 24'h0);
        end else begin
            first_d = b;
            ph      = P_DATA2;
        end
    endtask

    task automatic meta_done();
        if (mtype == META_END_TRACK) begin
            post_event(KIND_END_TRACK, 8'h00, 8'h00, 24'h0);
            trk = trk + 16'd1;
            cnt = '0;
            ph  = (trk >= hdr[31:16]) ? P_DONE : P_TRACK_HDR;
        end else begin
            ph  = P_DELTA;
            cnt = '0;
            if (first_d != 8'h00 && tempo_st != 24'h0)
                post_event(KIND_TEMPO, 8'h00, 8'h00, tempo_st);
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (ph)
            P_FILE_HDR: begin
                hdr = {hdr[39:0], b};
                cnt = cnt + 4'd1;
                if (cnt == FILE_HDR_BYTES) begin
                    cnt = '0;
                    ph  = (hdr[31:16] == 16'h0) ? P_DONE : P_TRACK_HDR;
                    post_event(KIND_HEADER, 8'h00, 8'h00, 24'h0);
                end
            end
            P_TRACK_HDR: begin
                cnt = cnt + 4'd1;
                if (cnt == TRACK_HDR_BYTES) begin
                    trk_time  = '0;
                    delta_acc = '0;
                    run_st    = '0;
                    act_st    = '0;
                    ph        = P_DELTA;
                    cnt       = '0;
                end
            end
            P_DELTA: begin
                if (cnt == 4'd0) begin
                    delta_acc = '0;
                    cnt       = 4'd1;
                end
                delta_acc = {delta_acc[24:0], b[6:0]};
                if (!b[7]) begin
                    trk_time = trk_time + delta_acc;
                    ph       = P_STATUS;
                end
            end
            P_STATUS: begin
                if (!b[7]) begin
                    if (run_st == 8'h00) begin
                        // stray data byte: flagged, then taken as a whole delta
                        post_event(KIND_BAD_STAT, 8'h00, 8'h00, 24'h0);
                        delta_acc = {24'h0, b};
                        trk_time  = trk_time + delta_acc;
                    end else begin
                        act_st = run_st;
                        data_first(b);
                    end
                end else if (b < STAT_SYSEX) begin
                    run_st = b;
                    act_st = b;
                    ph     = P_DATA1;
                end else begin
                    run_st = '0;
                    act_st = b;
                    if (b == STAT_META) begin
                        ph = P_META_TYPE;
                    end else if (b == STAT_SYSEX || b == STAT_SYSEX_ESC) begin
                        skip_len = '0;
                        ph       = P_SYSEX_LEN;
                    end else begin
                        ph  = P_DELTA;
                        cnt = '0;
                    end
                end
            end
            P_DATA1: data_first(b);
            P_DATA2: begin
                ph  = P_DELTA;
                cnt = '0;
                if (act_st[7:4] == HI_NOTE_OFF)
                    post_event(KIND_NOTE_OFF, first_d, b, 24'h0);
                else if (act_st[7:4] == HI_NOTE_ON && b == 8'h00)
                    post_event(KIND_NOTE_OFF, first_d, b, 24'h0);
                else if (act_st[7:4] == HI_NOTE_ON)
                    post_event(KIND_NOTE_ON, first_d, b, 24'h0);
                else
                    post_event(KIND_CHANNEL, 8'h00, 8'h00, 24'h0);
            end
            P_META_TYPE: begin
                mtype    = b;
                skip_len = '0;
                ph       = P_META_LEN;
            end
            P_META_LEN: begin
                skip_len = {skip_len[24:0], b[6:0]};
                if (!b[7]) begin
                    cnt     = '0;
                    first_d = (mtype == META_SET_TEMPO && tempo_st == 24'h0) ? 8'h01 : 8'h00;
                    if (skip_len == 32'h0)
                        meta_done();
                    else
                        ph = P_META_BODY;
                end
            end
            P_META_BODY: begin
                if (first_d != 8'h00 && cnt < 4'd3) begin
                    case (cnt)
                        4'd0:    tempo_st[23:16] = tempo_st[23:16] | b;
                        4'd1:    tempo_st[15:8]  = tempo_st[15:8] | b;
                        default: tempo_st[7:0]   = tempo_st[7:0] | b;
                    endcase
                    cnt = cnt + 4'd1;
                end
                skip_len = skip_len - 32'd1;
                if (skip_len == 32'h0)
                    meta_done();
            end
            P_SYSEX_LEN: begin
                skip_len = {skip_len[24:0], b[6:0]};
                if (!b[7]) begin
                    if (skip_len == 32'h0) begin
                        ph  = P_DELTA;
                        cnt = '0;
                    end else begin
                        ph = P_SYSEX_BODY;
                    end
                end
            end
            P_SYSEX_BODY: begin
                skip_len = skip_len - 32'd1;
                if (skip_len == 32'h0) begin
                    ph  = P_DELTA;
                    cnt = '0;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (idle_enable && $urandom_range(0, 11) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    // n low bytes of w, most significant first
    task automatic send_word(input logic [31:0] w, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    // variable-length quantity, shortest form
    task automatic send_delta(input logic [31:0] v);
        logic [6:0] grp [5];
        int n;
        n = 0;
        do begin
            grp[n] = v[6:0];
            v = v >> 7;
            n++;
        end while (v != 32'h0);
        for (int i = n - 1; i >= 0; i--)
            send_byte({i != 0, grp[i]});
    endtask

    task automatic send_chan(input logic [3:0] hi, input logic [3:0] ch,
                             input logic [7:0] d1, input logic [7:0] d2);
        send_byte({hi, ch});
        send_byte(d1);
        if (hi != HI_PROGRAM && hi != HI_PRESSURE)
            send_byte(d2);
    endtask

    task automatic send_meta(input logic [7:0] kind, input int len, input logic [47:0] body);
        send_byte(STAT_META);
        send_byte(kind);
        send_delta(len);
        for (int i = len - 1; i >= 0; i--)
            send_byte(body[8*i +: 8]);
    endtask

    task automatic send_sysex(input logic [7:0] code, input int len);
        send_byte(code);
        send_delta(len);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic open_track();
        send_word(TRACK_TAG, 4);
        send_word($urandom, 4);
    endtask

    // hold the input until every predicted event has come out
    task automatic wait_for_results();
        if (pending_events.size() != 0) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (pending_events.size() != 0);
        end
    endtask

    function automatic logic [7:0] system_byte();
        logic [7:0] v;
        v = 8'($urandom_range(STAT_SYS_FIRST, STAT_SYS_LAST - 8'd1));
        if (v >= STAT_SYSEX_ESC)
            v = v + 8'd1;
        return v;
    endfunction

    function automatic logic [7:0] random_data();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [31:0] random_delta();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, 15);
        if (pick < 85)
            return $urandom_range(0, 127);
        if (pick < 95)
            return $urandom_range(0, 16383);
        return $urandom;
    endfunction

    // finish whatever the stream is in the middle of, up to the next delta
    task automatic sync_to_delta();
        logic [7:0] b;
        while (!(ph == P_DELTA && cnt == 4'd0) && ph != P_DONE && ph != P_FILE_HDR) begin
            case (ph)
                P_DELTA: send_byte(8'($urandom_range(0, 127)));
                P_STATUS: begin
                    if (run_st != 8'h00)
                        send_byte(8'($urandom_range(0, 127)));
                    else
                        send_byte(system_byte());
                end
                P_META_TYPE: begin
                    b = 8'($urandom_range(0, 255));
                    if (b == META_END_TRACK)
                        b = META_TEXT;
                    send_byte(b);
                end
                P_META_LEN, P_SYSEX_LEN: send_byte(8'h00);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic random_event();
        int pick;
        logic [7:0] kind;
        logic [47:0] body;
        pick = $urandom_range(0, 99);
        body = 48'({$urandom, $urandom});
        send_delta(random_delta());
        if (pick < 30) begin
            send_chan($urandom_range(0, 1) ? HI_NOTE_ON : HI_NOTE_OFF,
                      4'($urandom_range(0, 15)),
                      random_data(), ($urandom_range(0, 4) == 0) ? 8'h00 : random_data());
        end else if (pick < 48) begin
            // running status, or a stray data byte when there is none
            send_byte(random_data());
        end else if (pick < 63) begin
            send_chan(HI_POLY_PRESS + 4'($urandom_range(0, 4)), 4'($urandom_range(0, 15)),
                      random_data(), random_data());
        end else if (pick < 73) begin
            kind = 8'($urandom_range(0, 255));
            if (kind == META_END_TRACK)
                kind = META_TEXT;
            if ($urandom_range(0, 5) == 0)
                kind = META_SET_TEMPO;
            send_meta(kind, $urandom_range(0, 6), body);
        end else if (pick < 81) begin
            send_sysex($urandom_range(0, 1) ? STAT_SYSEX : STAT_SYSEX_ESC,
                       ($urandom_range(0, 19) == 0) ? $urandom_range(128, 160)
                                                    : $urandom_range(0, 5));
        end else if (pick < 88) begin
            send_byte(system_byte());
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
        sync_to_delta();
    endtask

    task automatic random_track(input int budget);
        int start;
        sync_to_delta();
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            random_event();
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
        end
        send_delta(random_delta());
        send_meta(META_END_TRACK, $urandom_range(0, 3), 48'({$urandom, $urandom}));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_file_header();
        send_word(FILE_TAG, 4);
        send_word(32'd6, 4);
        send_word($urandom, 2);
        send_word(TRACK_COUNT, 2);
        send_word($urandom, 2);
    endtask

    task automatic test_note_events();
        open_track();
        // data byte before any status: bad status, then it counts as delta
        send_delta(0);
        send_byte(8'h3C);
        send_chan(HI_NOTE_ON, 4'h0, 8'h3C, 8'h64);
        // running status note on, velocity zero
        send_delta(16);
        send_byte(8'h3C);
        send_byte(8'h00);
        send_delta(0);
        send_chan(HI_NOTE_OFF, 4'hF, 8'h7F, 8'h7F);
        send_delta(0);
        send_chan(HI_NOTE_ON, 4'h9, 8'hFF, 8'hFF);
        send_delta(1);
        send_chan(HI_NOTE_ON, 4'h0, 8'h00, 8'h01);
        wait_for_results();
    endtask

    task automatic test_channel_messages();
        send_delta(0);
        send_chan(HI_POLY_PRESS, 4'h1, 8'h40, 8'h20);
        send_delta(0);
        send_chan(HI_CONTROL, 4'h5, 8'h07, 8'h7F);
        send_delta(5);
        send_chan(HI_PROGRAM, 4'h3, 8'h05, 8'h00);
        send_delta(5);
        send_byte(8'h06);
        send_delta(0);
        send_chan(HI_PRESSURE, 4'h0, 8'h40, 8'h00);
        send_delta(0);
        send_chan(HI_PITCH, 4'hF, 8'h00, 8'h40);
        send_delta(1);
        send_byte(8'h7F);
        send_byte(8'h7F);
    endtask

    task automatic test_system_and_sysex();
        send_delta(0);
        send_byte(STAT_SYS_FIRST);
        // running status is gone now
        send_delta(0);
        send_byte(8'h22);
        send_sysex(STAT_SYSEX, 3);
        send_delta(0);
        send_byte(STAT_SYSEX_ESC);
        send_byte(8'h80);
        send_byte(8'h02);
        send_word($urandom, 2);
        send_delta(0);
        send_sysex(STAT_SYSEX_ESC, 0);
        send_delta(0);
        send_byte(STAT_SYS_LAST);
        send_delta(3);
        send_chan(HI_NOTE_ON, 4'h2, 8'h30, 8'h40);
    endtask

    task automatic test_tempo_meta();
        send_delta(0);
        send_meta(META_TEXT, 3, 48'h414243);
        send_delta(0);
        send_meta(META_SET_TEMPO, 3, 48'h0);
        send_delta(0);
        send_meta(META_SET_TEMPO, 0, 48'h0);
        send_delta(0);
        send_meta(META_SET_TEMPO, 1, 48'h0);
        // first non-zero tempo; trailing bytes skipped
        send_delta(2);
        send_meta(META_SET_TEMPO, 5, 48'h07_A120_9988);
        send_delta(0);
        send_meta(META_SET_TEMPO, 3, 48'h01_0203);
        // padded two-byte length
        send_delta(0);
        send_byte(STAT_META);
        send_byte(META_TEXT);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h55);
    endtask

    task automatic test_long_deltas();
        send_delta(32'hFFFF_FFFF);
        send_chan(HI_NOTE_ON, 4'h0, 8'h40, 8'h40);
        // six-byte delta, upper bits fall off
        repeat (5) send_byte(8'hFF);
        send_byte(8'h7F);
        send_chan(HI_NOTE_OFF, 4'h0, 8'h40, 8'h00);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
        send_chan(HI_CONTROL, 4'h0, 8'h01, 8'h02);
        send_delta(32'h0FFF_FFFF);
        send_byte(8'h03);
        send_byte(8'h04);
    endtask

    task automatic test_end_of_track();
        send_delta(0);
        send_meta(META_END_TRACK, 2, 48'hAABB);
        wait_for_results();
    endtask

    task automatic test_random_tracks();
        for (int t = 1; t < TRACK_COUNT - 1; t++) begin
            idle_enable  = ($urandom_range(0, 3) != 0);
            stall_enable = ($urandom_range(0, 3) != 0);
            random_track(RANDOM_BYTES / (TRACK_COUNT - 1));
        end
    endtask

    task automatic test_quiet_track();
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
        random_track(RANDOM_BYTES / (TRACK_COUNT - 1));
    endtask

    task automatic test_after_last_track();
        repeat (16) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 4'd1) begin
            stall_left <= stall_left - 4'd1;
        end else if (stall_left == 4'd1) begin
            stall_left <= 4'd0;
            i_stall    <= 1'b0;
        end else if (stall_enable && $urandom_range(0, 11) == 0) begin
            stall_left <= 4'($urandom_range(1, 10));
            i_stall    <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_events
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected event, kind", 32'(o_event_kind), 32'h0);
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind)
                    report_mismatch("event_kind", 32'(o_event_kind), 32'(want.kind));
                if (o_track_number !== want.track)
                    report_mismatch("track_number", 32'(o_track_number), 32'(want.track));
                if (o_note_key !== want.key)
                    report_mismatch("note_key", 32'(o_note_key), 32'(want.key));
                if (o_note_velocity !== want.velocity)
                    report_mismatch("note_velocity", 32'(o_note_velocity),
                                    32'(want.velocity));
                if (o_delta_ticks !== want.delta)
                    report_mismatch("delta_ticks", o_delta_ticks, want.delta);
                if (o_absolute_ticks !== want.abs_time)
                    report_mismatch("absolute_ticks", o_absolute_ticks, want.abs_time);
                if (o_tempo_value !== want.tempo)
                    report_mismatch("tempo_value", 32'(o_tempo_value), 32'(want.tempo));
                if (o_file_format !== want.format)
                    report_mismatch("file_format", 32'(o_file_format), 32'(want.format));
                if (o_track_total !== want.total)
                    report_mismatch("track_total", 32'(o_track_total), 32'(want.total));
                if (o_time_division !== want.division)
                    report_mismatch("time_division", 32'(o_time_division),
                                    32'(want.division));
            end
        end
    end

    // no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_file_header();
        test_note_events();
        test_channel_messages();
        test_system_and_sysex();
        test_tempo_meta();
        test_long_deltas();
        test_end_of_track();
        test_random_tracks();
        test_quiet_track();
        test_after_last_track();
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        // output buffer is two deep: result register and skid slot
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
